// ----- hdl/lpg_pkg.sv -----
// Shared types, sizes and helper functions for the lexicographic permutation generator.
// No dependencies; every other file in hdl imports this package.
package lpg_pkg;

    // built size and derived widths
    localparam int MAX_POSITIONS = 8;
    localparam int IDX_W         = $clog2(MAX_POSITIONS);
    localparam int CNT_W         = $clog2(MAX_POSITIONS + 1);
    localparam int CFG_W         = 4;
    localparam int SLOT_W        = 3;
    localparam int OUT_SLOTS     = 8;
    localparam int ARR_W         = SLOT_W * OUT_SLOTS;
    localparam int SHOWN         = (MAX_POSITIONS < OUT_SLOTS) ? MAX_POSITIONS : OUT_SLOTS;
    localparam int ROUND_W       = IDX_W;
    localparam int RESET_COUNT   = 8;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [ROUND_W-1:0] round_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_id;
        logic load_out;
        logic cap_pivot;
        logic rd_succ;
        logic cap_pv;
        logic cap_succ;
        logic cap_sv;
        logic swap;
        logic sort_step;
        logic sort_odd;
    } lpg_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic last_perm;
    } lpg_stat_t;

    // one element as a 3-bit output slot
    function automatic logic [SLOT_W-1:0] slot_bits(input idx_t v);
        logic [IDX_W+SLOT_W-1:0] ext;
        begin
            ext = {{SLOT_W{1'b0}}, v};
            return ext[SLOT_W-1:0];
        end
    endfunction

    // clamp the raw register value to 1..MAX_POSITIONS
    function automatic cnt_t active_count(input logic [CFG_W-1:0] raw);
        cnt_t n;
        begin
            if (raw == '0)
            begin
                n = cnt_t'(1);
            end
            else if (int'(raw) > MAX_POSITIONS)
            begin
                n = cnt_t'(MAX_POSITIONS);
            end
            else
            begin
                n = cnt_t'(raw);
            end
            return n;
        end
    endfunction

endpackage

// ----- hdl/lpg_datapath.sv -----
// Datapath: arrangement cells, pivot and successor search, swap, tail sort, result register.
// Depends on lpg_pkg; driven by lpg_controller through lpg_cmd_t.
module lpg_datapath
    import lpg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  lpg_cmd_t             cmd,
    output lpg_stat_t            stat,
    output logic [ARR_W-1:0]     arrangement,
    output logic                 final_res
);

    idx_t             store_reg [MAX_POSITIONS];
    idx_t             store_next [MAX_POSITIONS];
    cnt_t             n_reg;
    idx_t             pivot_reg;
    idx_t             succ_reg;
    idx_t             pv_reg;
    idx_t             sv_reg;
    logic [ARR_W-1:0] arr_out_reg;
    logic             final_out_reg;

    idx_t             pivot_enc;
    logic             has_asc;
    idx_t             succ_enc;
    idx_t             rd_addr;
    idx_t             rd_data;
    logic [ARR_W-1:0] packed_arr;

    // packing of the active positions, unused slots zero
    always_comb
    begin
        packed_arr = '0;
        for (int p = 0; p < SHOWN; p++)
        begin
            if (cnt_t'(p) < n_reg)
            begin
                packed_arr[p*SLOT_W +: SLOT_W] = slot_bits(store_reg[p]);
            end
        end
    end

    // rightmost ascent over adjacent cells
    always_comb
    begin
        pivot_enc = '0;
        has_asc   = 1'b0;
        for (int p = 0; p < MAX_POSITIONS - 1; p++)
        begin
            if ((cnt_t'(p + 1) < n_reg) && (store_reg[p] < store_reg[p+1]))
            begin
                pivot_enc = idx_t'(p);
                has_asc   = 1'b1;
            end
        end
    end

    // rightmost cell after the pivot holding a larger value
    always_comb
    begin
        succ_enc = pivot_reg;
        for (int q = 1; q < MAX_POSITIONS; q++)
        begin
            if ((idx_t'(q) > pivot_reg) && (cnt_t'(q) < n_reg) && (store_reg[q] > pv_reg))
            begin
                succ_enc = idx_t'(q);
            end
        end
    end

    // single read port into the cells
    assign rd_addr = cmd.rd_succ ? succ_reg : pivot_reg;
    assign rd_data = store_reg[rd_addr];

    // next cell contents: identity load, swap or one odd-even sort round
    always_comb
    begin
        for (int e = 0; e < MAX_POSITIONS; e++)
        begin
            store_next[e] = store_reg[e];
        end
        if (cfg_we || cmd.load_id)
        begin
            for (int e = 0; e < MAX_POSITIONS; e++)
            begin
                store_next[e] = idx_t'(e);
            end
        end
        else if (cmd.swap)
        begin
            for (int e = 0; e < MAX_POSITIONS; e++)
            begin
                if (idx_t'(e) == pivot_reg)
                begin
                    store_next[e] = sv_reg;
                end
                else if (idx_t'(e) == succ_reg)
                begin
                    store_next[e] = pv_reg;
                end
            end
        end
        else if (cmd.sort_step)
        begin
            for (int i = 0; i < MAX_POSITIONS - 1; i++)
            begin
                if ((i[0] == cmd.sort_odd) && (idx_t'(i) > pivot_reg)
                    && (cnt_t'(i + 1) < n_reg) && (store_reg[i] > store_reg[i+1]))
                begin
                    store_next[i]   = store_reg[i+1];
                    store_next[i+1] = store_reg[i];
                end
            end
        end
    end

    // arrangement cells and active count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < MAX_POSITIONS; e++)
            begin
                store_reg[e] <= idx_t'(e);
            end
            n_reg <= active_count(CFG_W'(RESET_COUNT));
        end
        else
        begin
            for (int e = 0; e < MAX_POSITIONS; e++)
            begin
                store_reg[e] <= store_next[e];
            end
            if (cfg_we)
            begin
                n_reg <= active_count(cfg_wdata);
            end
        end
    end

    // search results, operands and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.cap_pivot)
        begin
            pivot_reg <= pivot_enc;
        end
        if (cmd.cap_pv)
        begin
            pv_reg <= rd_data;
        end
        if (cmd.cap_succ)
        begin
            succ_reg <= succ_enc;
        end
        if (cmd.cap_sv)
        begin
            sv_reg <= rd_data;
        end
        if (cmd.load_out)
        begin
            arr_out_reg   <= packed_arr;
            final_out_reg <= !has_asc;
        end
    end

    assign stat.last_perm = !has_asc;
    assign arrangement    = arr_out_reg;
    assign final_res      = final_out_reg;

endmodule

// ----- hdl/lpg_controller.sv -----
// Controller: one-hot sequencer for emit, pivot/successor search, swap and tail sort.
// Depends on lpg_pkg; commands lpg_datapath through lpg_cmd_t.
module lpg_controller
    import lpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      restart,
    output logic      out_valid,
    input  logic      out_ready,
    input  lpg_stat_t stat,
    output lpg_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EMIT  = 7'b0000010,
        ST_RD_PV = 7'b0000100,
        ST_SUCC  = 7'b0001000,
        ST_RD_SV = 7'b0010000,
        ST_SWAP  = 7'b0100000,
        ST_SORT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    round_t round_reg;
    round_t round_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_id = restart;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    if (stat.last_perm)
                    begin
                        cmd.load_id = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        cmd.cap_pivot = 1'b1;
                        state_next    = ST_RD_PV;
                    end
                end
            end
            ST_RD_PV:
            begin
                cmd.cap_pv = 1'b1;
                state_next = ST_SUCC;
            end
            ST_SUCC:
            begin
                cmd.cap_succ = 1'b1;
                state_next   = ST_RD_SV;
            end
            ST_RD_SV:
            begin
                cmd.rd_succ = 1'b1;
                cmd.cap_sv  = 1'b1;
                state_next  = ST_SWAP;
            end
            ST_SWAP:
            begin
                cmd.swap   = 1'b1;
                round_next = '0;
                state_next = ST_SORT;
            end
            ST_SORT:
            begin
                cmd.sort_step = 1'b1;
                cmd.sort_odd  = round_reg[0];
                round_next    = round_reg + round_t'(1);
                if (round_reg == round_t'(MAX_POSITIONS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hdl/lexicographic_permutation_generator.sv -----
// Each item (restart or continue) yields the current arrangement of the first positions_used
// positions, 3 bits per position with position 0 in the low bits, and a flag on the last
// (descending) arrangement, then steps to the next permutation in lexicographic order and
// wraps to the identity after the last one. Writing positions_used also reloads the identity.
// One item at a time: the emit state waits for the result register to drain; unless the emitted
// arrangement is the last, the pivot read, successor search, successor read and swap states
// follow, then MAX_POSITIONS rounds of odd-even neighbor swaps that reverse the tail.
// A new item is taken while the previous result still waits.
// Depends on lpg_pkg, lpg_controller and lpg_datapath.
module lexicographic_permutation_generator
    import lpg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             restart,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [ARR_W-1:0] arrangement,
    output logic             final_res,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    lpg_cmd_t  cmd;
    lpg_stat_t stat;

    // sequencer
    lpg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arrangement cells and result register
    lpg_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .stat        (stat),
        .arrangement (arrangement),
        .final_res   (final_res)
    );

endmodule

// ----- sim/lexicographic_permutation_generator_test.sv -----
// Self-checking bench for lexicographic_permutation_generator: a scoreboard class predicts
// each arrangement and last flag while tasks drive requests and positions_used writes.
// Depends on lpg_pkg and the generator RTL in hdl.
`timescale 1ns / 1ps

module lexicographic_permutation_generator_test;
    import lpg_pkg::*;

    // one predicted output item
    typedef struct {
        logic [ARR_W-1:0] arr;
        logic             last_flag;
    } perm_result_t;

    // predictor of the permutation walk and queue of pending arrangements
    class arrangement_scoreboard;
        idx_t             order [MAX_POSITIONS];
        logic [CFG_W-1:0] count_reg;
        perm_result_t     pending_perms [$];
        int               errors;

        function new();
            count_reg = CFG_W'(RESET_COUNT);
            errors    = 0;
            load_identity();
        endfunction

        function void load_identity();
            for (int p = 0; p < MAX_POSITIONS; p++)
            begin
                order[p] = idx_t'(p);
            end
        endfunction

        function void write_count(logic [CFG_W-1:0] v);
            count_reg = v;
            load_identity();
        endfunction

        function int active();
            int n;
            n = int'(count_reg);
            if (n < 1)
            begin
                n = 1;
            end
            if (n > MAX_POSITIONS)
            begin
                n = MAX_POSITIONS;
            end
            return n;
        endfunction

        // emit the current arrangement, then step to its successor
        function void advance_arrangement(bit rs);
            int           n;
            int           pivot;
            int           succ;
            int           lo;
            int           hi;
            bit           has_ascent;
            idx_t         t;
            perm_result_t r;
            n          = active();
            pivot      = 0;
            has_ascent = 0;
            if (rs)
            begin
                load_identity();
            end
            r.arr = '0;
            for (int p = 0; p < n && p < OUT_SLOTS; p++)
            begin
                r.arr |= ARR_W'(order[p] & 3'h7) << (SLOT_W * p);
            end
            // rightmost ascent
            for (int p = 0; p + 1 < n; p++)
            begin
                if (order[p] < order[p + 1])
                begin
                    pivot      = p;
                    has_ascent = 1;
                end
            end
            r.last_flag   = !has_ascent;
            pending_perms = {pending_perms, r};
            if (!has_ascent)
            begin
                load_identity();
                return;
            end
            // swap in the rightmost larger element, then reverse the tail
            succ = n - 1;
            while (succ > pivot && order[succ] <= order[pivot])
            begin
                succ--;
            end
            t            = order[pivot];
            order[pivot] = order[succ];
            order[succ]  = t;
            lo = pivot + 1;
            hi = n - 1;
            while (lo < hi)
            begin
                t         = order[lo];
                order[lo] = order[hi];
                order[hi] = t;
                lo++;
                hi--;
            end
        endfunction

        function void check_result(logic [ARR_W-1:0] arr, logic last_flag);
            perm_result_t r;
            if (pending_perms.size() == 0)
            begin
                $error("unexpected item: arrangement %h final_res %b", arr, last_flag);
                errors++;
                return;
            end
            r = pending_perms.pop_front();
            if (arr !== r.arr)
            begin
                $error("arrangement: expected %h, actual %h", r.arr, arr);
                errors++;
            end
            if (last_flag !== r.last_flag)
            begin
                $error("final_res: expected %b, actual %b", r.last_flag, last_flag);
                errors++;
            end
        endfunction

        function int pending();
            return pending_perms.size();
        endfunction
    endclass

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 60;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             restart;
    logic             out_valid;
    logic             out_ready;
    logic [ARR_W-1:0] arrangement;
    logic             final_res;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    arrangement_scoreboard sb;
    bit                    quiet;
    int                    hold_len;

    lexicographic_permutation_generator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .arrangement (arrangement),
        .final_res   (final_res),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // offer one request item, then idle for a drawn gap
    task automatic send_request(bit rs, bit no_gap);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        restart  <= rs;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.advance_arrangement(rs);
        gap = (quiet || no_gap) ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // drop valid and let every pending arrangement drain, then let the block settle
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write positions_used while idle
    task automatic write_positions(logic [CFG_W-1:0] v);
        drain_block();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.write_count(v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // receiver: random back-pressure with an occasional long hold
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_len > 0)
            begin
                gap      = hold_len;
                hold_len = 0;
            end
            else
            begin
                gap = quiet ? 0 : $urandom_range(0, 7);
            end
            if (gap > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                @(negedge clk);
                out_ready <= 1'b1;
            end
            do
            begin
                @(posedge clk);
            end
            while (!(out_valid && out_ready));
            sb.check_result(arrangement, final_res);
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [CFG_W-1:0] n_cfg;
        sb        = new();
        quiet     = 0;
        hold_len  = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        restart   = 1'b0;
        out_ready = 1'b1;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset size, then wrap at three positions
        send_request(1'b0, 1'b0);
        send_request(1'b0, 1'b0);
        send_request(1'b1, 1'b0);
        write_positions(CFG_W'(3));
        for (int k = 0; k < 8; k++)
        begin
            send_request(1'b0, 1'b0);
        end
        send_request(1'b1, 1'b0);
        // single position, zero treated as one, oversize saturates
        write_positions(CFG_W'(1));
        send_request(1'b0, 1'b0);
        send_request(1'b1, 1'b0);
        write_positions(CFG_W'(0));
        send_request(1'b0, 1'b0);
        send_request(1'b0, 1'b0);
        write_positions(CFG_W'(15));
        send_request(1'b0, 1'b0);
        send_request(1'b0, 1'b0);
        write_positions(CFG_W'(2));
        send_request(1'b0, 1'b0);
        send_request(1'b0, 1'b0);
        send_request(1'b0, 1'b0);

        // random phases, mostly long unbroken walks at small sizes
        for (int ph = 0; ph < 12; ph++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                n_cfg = CFG_W'($urandom_range(0, 15));
            end
            else
            begin
                n_cfg = CFG_W'($urandom_range(1, 5));
            end
            write_positions(n_cfg);
            quiet = (ph % 4 == 1);
            if (ph == 3)
            begin
                hold_len = HOLD_CYCLES;
            end
            for (int k = 0; k < 42; k++)
            begin
                send_request($urandom_range(0, 31) == 0, ph == 3);
            end
            quiet = 0;
        end

        drain_block();
        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #(200000 * 20);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
